[rtl/lfs_pkg.sv]
package lfs_pkg;

	localparam int SENSOR_COUNT = 5;
	localparam int CH_W         = 3;
	localparam int SAMPLE_W     = 8;
	localparam int STEER_W      = 3;

	// commands
	localparam logic [1:0] CMD_CAL   = 2'd0;
	localparam logic [1:0] CMD_FINAL = 2'd1;
	localparam logic [1:0] CMD_RUN   = 2'd2;

	// steering codes
	localparam logic [STEER_W-1:0] STEER_LEFT       = 3'd0;
	localparam logic [STEER_W-1:0] STEER_HARD_LEFT  = 3'd1;
	localparam logic [STEER_W-1:0] STEER_FORWARD    = 3'd2;
	localparam logic [STEER_W-1:0] STEER_HARD_RIGHT = 3'd3;
	localparam logic [STEER_W-1:0] STEER_RIGHT      = 3'd4;

	localparam logic [CH_W-1:0] LAST_CH = CH_W'(SENSOR_COUNT - 1);

	typedef struct packed {
		logic [1:0]          cmd;
		logic [CH_W-1:0]     channel;
		logic [SAMPLE_W-1:0] sample;
	} in_item_t;

	typedef struct packed {
		logic [STEER_W-1:0]      steer;
		logic [SENSOR_COUNT-1:0] line_pattern;
		logic                    left_pulse;
		logic                    left_reverse;
		logic                    right_pulse;
		logic                    right_reverse;
	} out_item_t;

	// per-item strobes, already qualified by the pipeline advancing
	typedef struct packed {
		logic cal;
		logic fin;
		logic run;
	} ctl_t;

	typedef struct packed {
		logic left_pulse;
		logic left_reverse;
		logic right_pulse;
		logic right_reverse;
	} pins_t;

	typedef struct packed {
		logic               known;
		logic [STEER_W-1:0] steer;
	} class_t;

	function automatic pins_t steer_pins(input logic [STEER_W-1:0] st);
		pins_t p;
		case (st)
			STEER_LEFT:       p = '{1'b0, 1'b0, 1'b1, 1'b0};
			STEER_HARD_LEFT:  p = '{1'b0, 1'b1, 1'b1, 1'b0};
			STEER_FORWARD:    p = '{1'b1, 1'b0, 1'b1, 1'b0};
			STEER_HARD_RIGHT: p = '{1'b1, 1'b0, 1'b0, 1'b1};
			STEER_RIGHT:      p = '{1'b1, 1'b0, 1'b0, 1'b0};
			default:          p = '{1'b1, 1'b0, 1'b1, 1'b0};
		endcase
		return p;
	endfunction

	function automatic class_t classify(input logic [SENSOR_COUNT-1:0] pat);
		class_t c;
		case (pat) inside
			5'h04, 5'h0E, 5'h1F: c = '{1'b1, STEER_FORWARD};
			5'h0C, 5'h08:        c = '{1'b1, STEER_LEFT};
			5'h02, 5'h06:        c = '{1'b1, STEER_RIGHT};
			5'h10, 5'h18, 5'h1C: c = '{1'b1, STEER_HARD_LEFT};
			5'h01, 5'h03, 5'h07: c = '{1'b1, STEER_HARD_RIGHT};
			default:             c = '{1'b0, STEER_FORWARD};
		endcase
		return c;
	endfunction

endpackage

[rtl/lfs_in_if.sv]
interface lfs_in_if;
	import lfs_pkg::*;

	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/lfs_out_if.sv]
interface lfs_out_if;
	import lfs_pkg::*;

	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/lfs_calib.sv]
module lfs_calib (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lfs_pkg::ctl_t                 ctl,
	input  logic [lfs_pkg::CH_W-1:0]      channel,
	input  logic [lfs_pkg::SAMPLE_W-1:0]  sample,
	output logic                          hit
);
	import lfs_pkg::*;

	logic [SAMPLE_W-1:0] min_q  [SENSOR_COUNT];
	logic [SAMPLE_W-1:0] max_q  [SENSOR_COUNT];
	logic [SAMPLE_W-1:0] trip_q [SENSOR_COUNT];
	logic [SAMPLE_W-1:0] trip_new [SENSOR_COUNT];
	logic [SAMPLE_W:0]   span [SENSOR_COUNT];
	logic [SAMPLE_W:0]   span_adj [SENSOR_COUNT];
	logic [SAMPLE_W-1:0] trip_sel;

	// trip = min + span/2, span signed, truncated toward zero
	always_comb begin
		for (int i = 0; i < SENSOR_COUNT; i++) begin
			span[i]     = {1'b0, max_q[i]} - {1'b0, min_q[i]};
			span_adj[i] = span[i] + {{SAMPLE_W{1'b0}}, span[i][SAMPLE_W]};
			trip_new[i] = min_q[i] + span_adj[i][SAMPLE_W:1];
		end
	end

	always_comb begin
		trip_sel = '0;
		for (int i = 0; i < SENSOR_COUNT; i++) begin
			if (channel == CH_W'(i)) begin
				trip_sel = trip_q[i];
			end
		end
	end

	assign hit = (sample >= trip_sel);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SENSOR_COUNT; i++) begin
				min_q[i]  <= '1;
				max_q[i]  <= '0;
				trip_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < SENSOR_COUNT; i++) begin
				if (ctl.cal && channel == CH_W'(i)) begin
					if (sample < min_q[i]) begin
						min_q[i] <= sample;
					end
					if (sample > max_q[i]) begin
						max_q[i] <= sample;
					end
				end
				if (ctl.fin) begin
					trip_q[i] <= trip_new[i];
				end
			end
		end
	end

endmodule

[rtl/lfs_steer.sv]
module lfs_steer (
	input  logic                      clk,
	input  logic                      arst_n,
	input  lfs_pkg::ctl_t             ctl,
	input  logic [lfs_pkg::CH_W-1:0]  channel,
	input  logic                      hit,
	output lfs_pkg::out_item_t        result
);
	import lfs_pkg::*;

	logic [SENSOR_COUNT-1:0] pattern_q;
	logic [SENSOR_COUNT-1:0] pattern_next;
	logic [STEER_W-1:0]      last_steer_q;
	logic [STEER_W-1:0]      steer;
	class_t                  cls;
	pins_t                   pins;

	// channel 0 lands on the MSB
	always_comb begin
		pattern_next = pattern_q;
		for (int i = 0; i < SENSOR_COUNT; i++) begin
			if (channel == CH_W'(i)) begin
				pattern_next[SENSOR_COUNT-1-i] = hit;
			end
		end
	end

	assign cls   = classify(pattern_next);
	assign steer = cls.known ? cls.steer : last_steer_q;
	assign pins  = steer_pins(steer);

	always_comb begin
		result.steer         = steer;
		result.line_pattern  = pattern_next;
		result.left_pulse    = pins.left_pulse;
		result.left_reverse  = pins.left_reverse;
		result.right_pulse   = pins.right_pulse;
		result.right_reverse = pins.right_reverse;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q    <= '0;
			last_steer_q <= STEER_FORWARD;
		end else if (ctl.run) begin
			pattern_q <= pattern_next;
			if (channel == LAST_CH && cls.known) begin
				last_steer_q <= cls.steer;
			end
		end
	end

endmodule

[rtl/line_follower_steering_top.sv]
// Line follower steering block.
//
// item channel (lfs_in_if): one reflectance sample per item, tagged with a
// command (calibrate, finalize trip points, run) and a sensor channel 0..4.
// Calibration items widen the channel's min/max window; finalize sets every
// trip point to the window midpoint; run items update the line pattern.
// Items for channels above 4 are dropped, except finalize, which ignores
// the channel field.
// result channel (lfs_out_if): one item per run sample of channel 4, with
// the steering code, the 5-bit line pattern and both motors' pin levels.
//
// An accepted item is registered in the input stage, where its state update
// and result are computed; a result, if the item produces one, is then
// registered in the result register, which holds result valid until the
// receiver takes it. Throughput is one item per cycle while no result is held up by a stalled receiver,
// set by the single input stage and single result register.
// Reset clears the windows (min 255, max 0), trip points to 0, the pattern
// to 0 and the remembered direction to forward; both channels come up idle.
// When the receiver stalls with a result pending, an item that would
// produce another result waits in the input stage and ready drops; items
// that produce no result keep flowing through.
module line_follower_steering_top (
	input logic       clk,
	input logic       arst_n,
	lfs_in_if.sink    item,
	lfs_out_if.source result
);
	import lfs_pkg::*;

	// input stage
	logic      valid_s1;
	in_item_t  data_s1;

	// result register
	logic      res_valid_q;
	out_item_t res_q;

	logic      ch_ok;
	logic      emits;
	logic      advance;
	ctl_t      ctl;
	logic      hit;
	out_item_t res_next;

	assign ch_ok = (data_s1.channel < CH_W'(SENSOR_COUNT));
	assign emits = (data_s1.cmd == CMD_RUN) && (data_s1.channel == LAST_CH);

	// stage 1 moves on unless it holds a result-producing item and the
	// result register is still occupied by an untaken result
	assign advance = valid_s1 && (!emits || !res_valid_q || result.ready);

	// state updates commit only when the item leaves stage 1
	always_comb begin
		ctl.cal = advance && (data_s1.cmd == CMD_CAL) && ch_ok;
		ctl.fin = advance && (data_s1.cmd == CMD_FINAL);
		ctl.run = advance && (data_s1.cmd == CMD_RUN) && ch_ok;
	end

	assign item.ready = !valid_s1 || advance;

	lfs_calib u_calib (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.channel (data_s1.channel),
		.sample  (data_s1.sample),
		.hit     (hit)
	);

	lfs_steer u_steer (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.channel (data_s1.channel),
		.hit     (hit),
		.result  (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			data_s1 <= item.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && emits) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emits) begin
			res_q <= res_next;
		end
	end

	assign result.valid = res_valid_q;
	assign result.data  = res_q;

	// ready only drops behind a stalled result
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!item.ready |-> (valid_s1 && emits && res_valid_q && !result.ready))
		else $error("input stalled without a pending result");

	// a result-producing item never overwrites an untaken result
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !result.ready) |=> (res_valid_q && $stable(res_q)))
		else $error("pending result lost or changed");

	// pin levels agree with the steering code
	a_pins: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> ({res_q.left_pulse, res_q.left_reverse,
			res_q.right_pulse, res_q.right_reverse} == steer_pins(res_q.steer)))
		else $error("motor pins disagree with steer code");

	a_steer_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (res_q.steer <= STEER_RIGHT))
		else $error("steer code out of range");

endmodule
